FILE: rtl/core/icf_pkg.sv
// Package for the integer constant folder: constants, types and helpers.
package icf_pkg;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned OpW        = 8;
  localparam int unsigned DataW      = 64;
  localparam int unsigned NumRegs    = 6;
  localparam int unsigned RegIdxW    = 3;

  localparam logic [RegIdxW-1:0] RegLit = 3'd0;
  localparam logic [RegIdxW-1:0] RegAdd = 3'd1;
  localparam logic [RegIdxW-1:0] RegSub = 3'd2;
  localparam logic [RegIdxW-1:0] RegMul = 3'd3;
  localparam logic [RegIdxW-1:0] RegDiv = 3'd4;
  localparam logic [RegIdxW-1:0] RegMod = 3'd5;

  typedef enum logic [2:0] {
    KindLit   = 3'd0,
    KindAdd   = 3'd1,
    KindSub   = 3'd2,
    KindMul   = 3'd3,
    KindDiv   = 3'd4,
    KindMod   = 3'd5,
    KindOther = 3'd6
  } kind_e;

  // Commands from the controller to the row of stack cells.
  typedef struct packed {
    logic             push;   // write top+1 with value
    logic             pop_bottom; // shift all entries down one place
    logic             fold;   // write top-1 with value (after pop of top)
  } cell_cmd_t;

endpackage : icf_pkg

FILE: rtl/core/icf_cell.sv
// One literal stack cell: holds one entry, can load or take its upper neighbour.
module icf_cell #(
  parameter int unsigned DataW = icf_pkg::DataW
) (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic [DataW-1:0] load_data_i,
  input  logic             shift_i,
  input  logic [DataW-1:0] upper_i,
  output logic [DataW-1:0] data_o
);

  logic [DataW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= load_data_i;
    end else if (shift_i) begin
      data_q <= upper_i;
    end
  end

  assign data_o = data_q;

endmodule : icf_cell

FILE: rtl/core/icf_divider.sv
// Iterative signed 64-bit divider, one quotient bit per cycle.
module icf_divider #(
  parameter int unsigned DataW = icf_pkg::DataW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             done_o,
  output logic [DataW-1:0] quot_o,
  output logic [DataW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(DataW + 1);

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] quo_q, rem_q, den_q;
  logic             qneg_q, rneg_q;
  logic [DataW:0]   trial;
  logic [DataW-1:0] ta, sa;

  assign ta = dividend_i[DataW-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign sa = divisor_i[DataW-1]  ? (~divisor_i + 1'b1)  : divisor_i;
  assign trial = {rem_q, quo_q[DataW-1]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DataW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= ta;
      rem_q  <= '0;
      den_q  <= sa;
      qneg_q <= dividend_i[DataW-1] ^ divisor_i[DataW-1];
      rneg_q <= dividend_i[DataW-1];
    end else if (busy_q) begin
      if (!trial[DataW]) begin
        rem_q <= trial[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DataW-2:0], quo_q[DataW-1]};
        quo_q <= {quo_q[DataW-2:0], 1'b0};
      end
    end
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  // final-step results are formed from the registered values in the cycle after done_o
  assign quot_o = qneg_q ? (~quo_q + 1'b1) : quo_q;
  assign rem_o  = rneg_q ? (~rem_q + 1'b1) : rem_q;

endmodule : icf_divider

FILE: rtl/core/int_constant_folder.sv
// Top level of the integer constant folder: controller, stack cell row and divider.
//
//  channel | dir | tdata fields (low bit up)                      | tuser / tlast
//  s_axis  | in  | opcode[7:0] operand[71:8] aux_operand[135:72]    | tlast=block_end
//  m_axis  | out | out_opcode[7:0] out_operand[71:8] out_aux[135:72]| tlast=out_last
//  cfg     | in  | cfg_we_i, cfg_idx_i[2:0], cfg_data_i[7:0]        | -
//
// Pushes and folds by add/sub finish in StExec; mul adds one register stage, StMul.
// Div/mod run through the bit-serial divider.
// Flushes emit one held literal per output transfer, then any unfolded instruction.
// A result waits in the output register; a further output stalls until it is taken.
// Reset clears the held count and state; data and stack cells hold no reset value.
module int_constant_folder #(
  parameter int unsigned StackDepth = icf_pkg::StackDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [135:0]                 s_axis_tdata,  // opcode, operand, aux_operand
  input  logic                         s_axis_tlast,  // block_end
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [135:0]                 m_axis_tdata,  // out_opcode, out_operand, out_aux
  output logic                         m_axis_tlast,  // out_last
  input  logic                         cfg_we_i,
  input  logic [icf_pkg::RegIdxW-1:0]  cfg_idx_i,
  input  logic [icf_pkg::OpW-1:0]      cfg_data_i
);

  localparam int unsigned DataW = icf_pkg::DataW;
  localparam int unsigned HalfW = DataW / 2;
  localparam int unsigned OpW   = icf_pkg::OpW;
  localparam int unsigned CntW  = $clog2(StackDepth + 1);
  localparam int unsigned IdxW  = $clog2(StackDepth);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StExec  = 6'b000010,
    StMul   = 6'b000100,
    StDiv   = 6'b001000,
    StFlush = 6'b010000,
    StEmit  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [OpW-1:0] regs_q [icf_pkg::NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(icf_pkg::NumRegs); i++) regs_q[i] <= OpW'(i);
    end else if (cfg_we_i && (cfg_idx_i < icf_pkg::RegIdxW'(icf_pkg::NumRegs))) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // captured instruction
  logic [OpW-1:0]   op_q;
  logic [DataW-1:0] a_q, b_q;
  logic             end_q;
  icf_pkg::kind_e   kind_q, kind_in;

  always_comb begin
    logic [OpW-1:0] o;
    o = s_axis_tdata[OpW-1:0];
    if (o == regs_q[icf_pkg::RegLit])      kind_in = icf_pkg::KindLit;
    else if (o == regs_q[icf_pkg::RegAdd]) kind_in = icf_pkg::KindAdd;
    else if (o == regs_q[icf_pkg::RegSub]) kind_in = icf_pkg::KindSub;
    else if (o == regs_q[icf_pkg::RegMul]) kind_in = icf_pkg::KindMul;
    else if (o == regs_q[icf_pkg::RegDiv]) kind_in = icf_pkg::KindDiv;
    else if (o == regs_q[icf_pkg::RegMod]) kind_in = icf_pkg::KindMod;
    else                                   kind_in = icf_pkg::KindOther;
  end

  // stack cell row
  logic [DataW-1:0] cell_data [StackDepth];
  logic [StackDepth-1:0] cell_load;
  logic                  cell_shift;
  logic [DataW-1:0]      load_val;
  logic [CntW-1:0]       cnt_q, cnt_d;

  for (genvar g = 0; g < StackDepth; g++) begin : g_cell
    logic [DataW-1:0] upper;
    if (g == StackDepth - 1) begin : g_top
      assign upper = cell_data[g];
    end else begin : g_mid
      assign upper = cell_data[g+1];
    end
    icf_cell #(.DataW(DataW)) u_cell (
      .clk_i      (clk_i),
      .load_i     (cell_load[g]),
      .load_data_i(load_val),
      .shift_i    (cell_shift),
      .upper_i    (upper),
      .data_o     (cell_data[g])
    );
  end

  // top and second entries
  logic [DataW-1:0] top_v, sec_v;
  always_comb begin
    top_v = '0;
    sec_v = '0;
    for (int i = 0; i < int'(StackDepth); i++) begin
      if (CntW'(i + 1) == cnt_q) top_v = cell_data[i];
      if (CntW'(i + 2) == cnt_q) sec_v = cell_data[i];
    end
  end

  // multiplier stage and divider
  // low half of the product from half-width partial products; cross terms only
  // reach the upper half, so their low halves suffice
  logic [HalfW-1:0] top_lo, top_hi, sec_lo, sec_hi;
  logic [DataW-1:0] mul_lo_q;
  logic [HalfW-1:0] mul_mid_q;
  logic [DataW-1:0] mul_res;
  logic             div_start;
  logic             div_done;
  logic [DataW-1:0] div_quo, div_rem;
  logic             div_wait_q;

  assign {top_hi, top_lo} = top_v;
  assign {sec_hi, sec_lo} = sec_v;
  assign mul_res = mul_lo_q + {mul_mid_q, {HalfW{1'b0}}};

  icf_divider #(.DataW(DataW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(top_v),
    .divisor_i (sec_v),
    .done_o    (div_done),
    .quot_o    (div_quo),
    .rem_o     (div_rem)
  );

  // output register
  logic             ov_q, ov_d;
  logic [OpW-1:0]   oop_q, oop_d;
  logic [DataW-1:0] oa_q, oa_d, ob_q, ob_d;
  logic             ol_q, ol_d;
  logic [IdxW-1:0]  fidx_q, fidx_d;
  logic             emit_after_q, emit_after_d;
  logic             div_wait_d;
  logic             out_free;

  assign out_free = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cell_load    = '0;
    cell_shift   = 1'b0;
    load_val     = a_q;
    ov_d         = ov_q && !m_axis_tready;
    oop_d        = oop_q;
    oa_d         = oa_q;
    ob_d         = ob_q;
    ol_d         = ol_q;
    fidx_d       = fidx_q;
    emit_after_d = emit_after_q;
    div_start    = 1'b0;
    div_wait_d   = div_wait_q;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) state_d = StExec;
      end
      StExec: begin
        if (kind_q == icf_pkg::KindLit) begin
          if (cnt_q == CntW'(StackDepth)) begin
            if (out_free) begin
              ov_d = 1'b1; oop_d = regs_q[icf_pkg::RegLit];
              oa_d = cell_data[0]; ob_d = '0; ol_d = !end_q;
              cell_shift = 1'b1;
              cell_load[IdxW'(StackDepth - 1)] = 1'b1;
              // shift and load collide at top: load wins in the cell
              state_d = end_q ? StFlush : StIdle;
              fidx_d = '0; emit_after_d = 1'b0;
            end
          end else begin
            cell_load[cnt_q[IdxW-1:0]] = 1'b1;
            cnt_d = cnt_q + 1'b1;
            state_d = end_q ? StFlush : StIdle;
            fidx_d = '0; emit_after_d = 1'b0;
          end
        end else if (kind_q == icf_pkg::KindOther ||
                     cnt_q < CntW'(2)) begin
          state_d = StFlush; fidx_d = '0; emit_after_d = 1'b1;
        end else if (kind_q == icf_pkg::KindAdd) begin
          load_val = top_v + sec_v;
          cell_load[IdxW'(cnt_q - CntW'(2))] = 1'b1;
          cnt_d = cnt_q - 1'b1;
          state_d = end_q ? StFlush : StIdle; fidx_d = '0; emit_after_d = 1'b0;
        end else if (kind_q == icf_pkg::KindSub) begin
          load_val = top_v - sec_v;
          cell_load[IdxW'(cnt_q - CntW'(2))] = 1'b1;
          cnt_d = cnt_q - 1'b1;
          state_d = end_q ? StFlush : StIdle; fidx_d = '0; emit_after_d = 1'b0;
        end else if (kind_q == icf_pkg::KindMul) begin
          state_d = StMul;
        end else if (sec_v == '0) begin
          state_d = StFlush; fidx_d = '0; emit_after_d = 1'b1;
        end else begin
          div_start = 1'b1; div_wait_d = 1'b0; state_d = StDiv;
        end
      end
      StMul: begin
        load_val = mul_res;
        cell_load[IdxW'(cnt_q - CntW'(2))] = 1'b1;
        cnt_d = cnt_q - 1'b1;
        state_d = end_q ? StFlush : StIdle; fidx_d = '0; emit_after_d = 1'b0;
      end
      StDiv: begin
        if (div_wait_q) begin
          load_val = (kind_q == icf_pkg::KindDiv) ? div_quo : div_rem;
          cell_load[IdxW'(cnt_q - CntW'(2))] = 1'b1;
          cnt_d = cnt_q - 1'b1;
          div_wait_d = 1'b0;
          state_d = end_q ? StFlush : StIdle; fidx_d = '0; emit_after_d = 1'b0;
        end else if (div_done) begin
          div_wait_d = 1'b1;
        end
      end
      StFlush: begin
        if (CntW'(fidx_q) >= cnt_q) begin
          cnt_d = '0;
          state_d = emit_after_q ? StEmit : StIdle;
        end else if (out_free) begin
          ov_d = 1'b1; oop_d = regs_q[icf_pkg::RegLit];
          oa_d = cell_data[fidx_q]; ob_d = '0;
          ol_d = !emit_after_q && (CntW'(fidx_q) + 1'b1 == cnt_q);
          if (CntW'(fidx_q) + 1'b1 == cnt_q) begin
            cnt_d = '0;
            state_d = emit_after_q ? StEmit : StIdle;
          end else begin
            fidx_d = fidx_q + 1'b1;
          end
        end
      end
      StEmit: begin
        if (out_free) begin
          ov_d = 1'b1; oop_d = op_q; oa_d = a_q; ob_d = b_q; ol_d = 1'b1;
          state_d = StIdle;
          // emitted op after the flush: stack already empty
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      ov_q         <= 1'b0;
      fidx_q       <= '0;
      emit_after_q <= 1'b0;
      div_wait_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      ov_q         <= ov_d;
      fidx_q       <= fidx_d;
      emit_after_q <= emit_after_d;
      div_wait_q   <= div_wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oop_q     <= oop_d;
    oa_q      <= oa_d;
    ob_q      <= ob_d;
    ol_q      <= ol_d;
    mul_lo_q  <= DataW'(top_lo) * DataW'(sec_lo);
    mul_mid_q <= top_lo * sec_hi + top_hi * sec_lo;
    if (s_axis_tvalid && s_axis_tready) begin
      op_q   <= s_axis_tdata[OpW-1:0];
      a_q    <= s_axis_tdata[OpW+DataW-1:OpW];
      b_q    <= s_axis_tdata[OpW+2*DataW-1:OpW+DataW];
      end_q  <= s_axis_tlast;
      kind_q <= kind_in;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {ob_q, oa_q, oop_q};
  assign m_axis_tlast  = ol_q;

endmodule : int_constant_folder

FILE: dv/int_constant_folder_tb.sv
// Testbench for the integer constant folder: stream driver, predictor and result checker.
module int_constant_folder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [icf_pkg::DataW-1:0] aux;
    logic [icf_pkg::DataW-1:0] operand;
    logic [icf_pkg::OpW-1:0]   opcode;
    logic                      last;
  } instr_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic [icf_pkg::RegIdxW-1:0] cfg_idx_i = '0;
  logic [icf_pkg::OpW-1:0] cfg_data_i = '0;

  int_constant_folder DUT (.*);

  always #1 clk_i = ~clk_i;

  // Predictor state
  logic [icf_pkg::OpW-1:0]   codes [icf_pkg::NumRegs];
  logic [icf_pkg::DataW-1:0] lits [icf_pkg::StackDepth];
  int unsigned               n_held;

  instr_t pending_q[$];   // items waiting for the driver
  instr_t folded_q[$];    // expected output instructions
  int send_idle_pct, recv_stall_pct, hold_off;
  int errors, cycles;
  bit done;

  function automatic icf_pkg::kind_e classify(logic [icf_pkg::OpW-1:0] op);
    for (int k = 0; k < icf_pkg::NumRegs; k++)
      if (op == codes[k]) return icf_pkg::kind_e'(k);
    return icf_pkg::KindOther;
  endfunction

  function automatic void emit(logic [icf_pkg::OpW-1:0] op, logic [icf_pkg::DataW-1:0] a,
                               logic [icf_pkg::DataW-1:0] b);
    instr_t r;
    r.opcode = op; r.operand = a; r.aux = b; r.last = 1'b0;
    folded_q = {folded_q, r};
  endfunction

  function automatic void flush_lits();
    for (int i = 0; i < n_held; i++) emit(codes[icf_pkg::RegLit], lits[i], '0);
    n_held = 0;
  endfunction

  function automatic void fold_instr(instr_t it);
    icf_pkg::kind_e k;
    int n_prior;
    logic [icf_pkg::DataW-1:0] t, s, r, ta, sa, q;
    bit ok;
    n_prior = folded_q.size();
    k = classify(it.opcode);
    if (k == icf_pkg::KindLit) begin
      if (n_held >= icf_pkg::StackDepth) begin
        emit(codes[icf_pkg::RegLit], lits[0], '0);
        for (int i = 0; i < icf_pkg::StackDepth - 1; i++) lits[i] = lits[i+1];
        n_held = icf_pkg::StackDepth - 1;
      end
      lits[n_held] = it.operand;
      n_held++;
    end else if (k != icf_pkg::KindOther) begin
      if (n_held == 0) emit(it.opcode, it.operand, it.aux);
      else if (n_held == 1) begin
        emit(codes[icf_pkg::RegLit], lits[0], '0);
        n_held = 0;
        emit(it.opcode, it.operand, it.aux);
      end else begin
        t = lits[n_held-1]; s = lits[n_held-2]; ok = 1; r = '0;
        case (k)
          icf_pkg::KindAdd: r = t + s;
          icf_pkg::KindSub: r = t - s;
          icf_pkg::KindMul: r = t * s;
          default: begin
            if (s == 0) ok = 0;
            else begin
              ta = t[63] ? -t : t;
              sa = s[63] ? -s : s;
              if (k == icf_pkg::KindDiv) begin
                q = ta / sa;
                r = (t[63] != s[63]) ? -q : q;
              end else begin
                q = ta % sa;
                r = t[63] ? -q : q;
              end
            end
          end
        endcase
        if (ok) begin
          n_held--;
          lits[n_held-1] = r;
        end else begin
          flush_lits();
          emit(it.opcode, it.operand, it.aux);
        end
      end
    end else begin
      flush_lits();
      emit(it.opcode, it.operand, it.aux);
    end
    if (it.last) flush_lits();
    if (folded_q.size() > n_prior) folded_q[folded_q.size()-1].last = 1'b1;
  endfunction

  // Driver
  always @(posedge clk_i) begin
    if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        instr_t it;
        it = pending_q[0];
        pending_q.delete(0);
        fold_instr(it);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {it.aux, it.operand, it.opcode};
        s_axis_tlast <= it.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      instr_t want;
      if (folded_q.size() == 0) begin
        $display("%0t: unexpected transfer op=%h a=%h b=%h last=%b", $time,
                 m_axis_tdata[7:0], m_axis_tdata[71:8], m_axis_tdata[135:72], m_axis_tlast);
        errors++;
      end else begin
        want = folded_q[0];
        folded_q.delete(0);
        if ({m_axis_tdata, m_axis_tlast} !== {want.aux, want.operand, want.opcode, want.last}) begin
          $display("%0t: mismatch exp op=%h a=%h b=%h last=%b got op=%h a=%h b=%h last=%b",
                   $time, want.opcode, want.operand, want.aux, want.last,
                   m_axis_tdata[7:0], m_axis_tdata[71:8], m_axis_tdata[135:72], m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1500000 && !done) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [icf_pkg::DataW-1:0] rand_val();
    case ($urandom_range(7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '1;
      3: return '0;
      4: return icf_pkg::DataW'($urandom_range(9)) - 64'd4;
      5: return {$urandom, $urandom};
      default: return icf_pkg::DataW'(signed'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  function automatic void add_item(logic [icf_pkg::OpW-1:0] op, logic [icf_pkg::DataW-1:0] a,
                                   logic [icf_pkg::DataW-1:0] b, logic e);
    instr_t it;
    it.opcode = op; it.operand = a; it.aux = b; it.last = e;
    pending_q = {pending_q, it};
  endfunction

  function automatic logic [icf_pkg::OpW-1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 45) return codes[icf_pkg::RegLit];
    if (r < 90) return codes[icf_pkg::RegAdd + $urandom_range(4)];
    return icf_pkg::OpW'($urandom);
  endfunction

  task automatic write_cfg(logic [icf_pkg::RegIdxW-1:0] idx, logic [icf_pkg::OpW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    codes[idx] = val;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || s_axis_tvalid || folded_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic random_phase(int n_items, int idle, int stall);
    send_idle_pct = idle; recv_stall_pct = stall;
    for (int i = 0; i < n_items; i++)
      add_item(pick_op(), rand_val(), {$urandom, $urandom}, $urandom_range(9) == 0);
    add_item(codes[icf_pkg::RegLit], rand_val(), '0, 1'b1);
    drain();
  endtask

  initial begin
    for (int k = 0; k < icf_pkg::NumRegs; k++) codes[k] = icf_pkg::OpW'(k);
    n_held = 0;
    errors = 0; cycles = 0; hold_off = 0; done = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: add, div, mod and mul folds, wrap, min/-1, div by zero, passthrough, full stack.
    add_item(codes[icf_pkg::RegAdd], 64'd7, 64'd9, 1'b0);
    add_item(codes[icf_pkg::RegLit], 64'd5, '0, 1'b0);
    add_item(codes[icf_pkg::RegSub], '1, '1, 1'b0);
    add_item(codes[icf_pkg::RegLit], 64'h7fff_ffff_ffff_ffff, '0, 1'b0);
    add_item(codes[icf_pkg::RegLit], 64'd1, '0, 1'b0);
    add_item(codes[icf_pkg::RegAdd], '0, '0, 1'b0);
    add_item(codes[icf_pkg::RegLit], -64'sd1, '0, 1'b0);
    add_item(codes[icf_pkg::RegLit], 64'h8000_0000_0000_0000, '0, 1'b0);
    add_item(codes[icf_pkg::RegDiv], '0, '0, 1'b0);
    add_item(codes[icf_pkg::RegLit], -64'sd1, '0, 1'b0);
    add_item(codes[icf_pkg::RegLit], 64'h8000_0000_0000_0000, '0, 1'b0);
    add_item(codes[icf_pkg::RegMod], '0, '0, 1'b0);
    add_item(codes[icf_pkg::RegLit], 64'd0, '0, 1'b0);
    add_item(codes[icf_pkg::RegLit], -64'sd7, '0, 1'b0);
    add_item(codes[icf_pkg::RegDiv], 64'd3, 64'd4, 1'b0);
    add_item(codes[icf_pkg::RegLit], 64'd3, '0, 1'b0);
    add_item(codes[icf_pkg::RegLit], -64'sd7, '0, 1'b0);
    add_item(codes[icf_pkg::RegMul], '0, '0, 1'b0);
    add_item(8'hff, 64'h1234, 64'h5678, 1'b1);
    for (int i = 0; i < 18; i++)
      add_item(codes[icf_pkg::RegLit], 64'(i) - 64'd9, '0, i == 17);
    drain();

    random_phase(45, 0, 0);
    random_phase(45, 71, 0);

    // Long receiver hold-off while the sender keeps offering.
    hold_off = 400;
    random_phase(25, 0, 0);

    write_cfg(icf_pkg::RegLit, 8'hff);
    write_cfg(icf_pkg::RegAdd, 8'h00);
    write_cfg(icf_pkg::RegSub, 8'h80);
    write_cfg(icf_pkg::RegMul, 8'h7f);
    write_cfg(icf_pkg::RegDiv, 8'h01);
    write_cfg(icf_pkg::RegMod, 8'hfe);
    random_phase(35, 0, 71);

    // Overlapping codes: first match wins.
    write_cfg(icf_pkg::RegSub, 8'h00);
    write_cfg(icf_pkg::RegMod, 8'h01);
    random_phase(35, 11, 11);

    done = 1;
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: int_constant_folder.f
rtl/core/icf_pkg.sv
rtl/core/icf_cell.sv
rtl/core/icf_divider.sv
rtl/core/int_constant_folder.sv
dv/int_constant_folder_tb.sv
